@@ hdl/cbs_pkg.sv @@
package cbs_pkg;

  // fixed point and field widths
  localparam int FRAC_BITS      = 16;
  localparam int DEF_MAX_POINTS = 64;
  localparam int CNT_W          = 7;
  localparam int PIDX_W         = 6;
  localparam int COMP_W         = 32;
  localparam int POS_W          = FRAC_BITS + 1;
  localparam int U_W            = 24;
  localparam int WGT_W          = 24;
  localparam int NUM_W          = 25;
  localparam int PROD_W         = NUM_W + WGT_W;
  localparam int PP_W           = WGT_W + COMP_W;
  localparam int ACC_W          = PP_W + 2;
  localparam int OPS_N          = 12;
  localparam int OPI_W          = 4;

  // item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // floor divide by three through a biased reciprocal
  localparam logic [31:0] RECIP3    = 32'hAAAA_AAAB;
  localparam logic [31:0] DIV3_BIAS = 32'h6000_0000;
  localparam logic [30:0] DIV3_OFF  = 31'h2000_0000;

  // one step of the basis recurrence: c[tgt] (+)= (num * c[src]) / span
  typedef struct packed {
    logic [1:0] tgt;
    logic       u_minus;
    logic [2:0] ka;
    logic [1:0] src;
    logic [2:0] dk0;
    logic [2:0] dk1;
    logic       acc;
  } rop_t;

  // controller to datapath commands
  typedef struct packed {
    logic             take;
    logic             prep;
    logic             wmul;
    logic             wdiv;
    logic             wwb;
    logic             prd;
    logic             pmul;
    logic             pacc;
    logic             out_load;
    logic [OPI_W-1:0] op_idx;
    logic [1:0]       pt_idx;
  } cmd_t;

  // degree three recurrence unrolled in evaluation order
  function automatic rop_t recur_op(input logic [OPI_W-1:0] idx);
    rop_t r;
    r = '0;
    case (idx)
      4'd0:    r = '{2'd2, 1'b0, 3'd3, 2'd3, 3'd3, 3'd2, 1'b0};
      4'd1:    r = '{2'd3, 1'b1, 3'd2, 2'd3, 3'd3, 3'd2, 1'b0};
      4'd2:    r = '{2'd1, 1'b0, 3'd3, 2'd2, 3'd3, 3'd1, 1'b0};
      4'd3:    r = '{2'd2, 1'b1, 3'd1, 2'd2, 3'd3, 3'd1, 1'b0};
      4'd4:    r = '{2'd2, 1'b0, 3'd4, 2'd3, 3'd4, 3'd2, 1'b1};
      4'd5:    r = '{2'd3, 1'b1, 3'd2, 2'd3, 3'd4, 3'd2, 1'b0};
      4'd6:    r = '{2'd0, 1'b0, 3'd3, 2'd1, 3'd3, 3'd0, 1'b0};
      4'd7:    r = '{2'd1, 1'b1, 3'd0, 2'd1, 3'd3, 3'd0, 1'b0};
      4'd8:    r = '{2'd1, 1'b0, 3'd4, 2'd2, 3'd4, 3'd1, 1'b1};
      4'd9:    r = '{2'd2, 1'b1, 3'd1, 2'd2, 3'd4, 3'd1, 1'b0};
      4'd10:   r = '{2'd2, 1'b0, 3'd5, 2'd3, 3'd5, 3'd2, 1'b1};
      4'd11:   r = '{2'd3, 1'b1, 3'd2, 2'd3, 3'd5, 3'd2, 1'b0};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/cbs_ifs.sv @@
interface cbs_in_if;
  import cbs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [PIDX_W-1:0]        point_index;
  logic signed [COMP_W-1:0] in_x;
  logic signed [COMP_W-1:0] in_y;
  logic signed [COMP_W-1:0] in_z;
  logic signed [COMP_W-1:0] in_w;
  logic [POS_W-1:0]         curve_pos;
  modport source (output valid, op, point_index, in_x, in_y, in_z, in_w, curve_pos,
                  input ready);
  modport sink (input valid, op, point_index, in_x, in_y, in_z, in_w, curve_pos,
                output ready);
endinterface

interface cbs_out_if;
  import cbs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] out_x;
  logic signed [COMP_W-1:0] out_y;
  logic signed [COMP_W-1:0] out_z;
  logic signed [COMP_W-1:0] out_w;
  logic [PIDX_W-1:0]        first_index;
  modport source (output valid, out_x, out_y, out_z, out_w, first_index, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, first_index, output ready);
endinterface

interface cbs_cfg_if;
  import cbs_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ hdl/cubic_bspline_evaluator.sv @@
// Clamped uniform cubic B-spline evaluator.
// in_port carries one word per item: op 0 stores a four-component Q16.16
// control point at point_index (no result, taken back to back);
// op 1 evaluates the curve at curve_pos (Q1.16, clamped to [0,1]).
// out_port returns one word per evaluate: the weighted point, saturated to
// Q16.16, and the index of the first of the four points used.
// cfg_port sets point_count (reset value 4); write it only while idle.
// After an evaluate is taken, in_port stays closed until its result enters the
// output register, so a new evaluate is taken only after the last one is done.
// The evaluate runs the twelve-step basis recurrence on one shared multiply
// and divide unit, each step a multiply, a divide and a write back, then four
// passes over the single table read port.
// A finished result waits in the output register while out_port stalls and
// in_port stays open; a following evaluate that finishes while that register
// is still full holds in_port.ready low until the register frees up.
// Reset clears the sequencer and the output valid; control point slots hold
// no defined value until written.
module cubic_bspline_evaluator #(
  parameter int MAX_POINTS = cbs_pkg::DEF_MAX_POINTS
) (
  input logic       clk,
  input logic       rst_n,
  cbs_in_if.sink    in_port,
  cbs_out_if.source out_port,
  cbs_cfg_if.sink   cfg_port
);
  import cbs_pkg::*;

  cmd_t cmd;

  assign cfg_port.ready = 1'b1;

  cbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_port.valid),
    .in_op     (in_port.op),
    .in_ready  (in_port.ready),
    .out_valid (out_port.valid),
    .out_ready (out_port.ready),
    .cmd       (cmd)
  );

  cbs_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_op       (in_port.op),
    .point_index (in_port.point_index),
    .in_x        (in_port.in_x),
    .in_y        (in_port.in_y),
    .in_z        (in_port.in_z),
    .in_w        (in_port.in_w),
    .curve_pos   (in_port.curve_pos),
    .cfg_we      (cfg_port.valid),
    .cfg_data    (cfg_port.data),
    .out_x       (out_port.out_x),
    .out_y       (out_port.out_y),
    .out_z       (out_port.out_z),
    .out_w       (out_port.out_w),
    .first_index (out_port.first_index)
  );

endmodule

@@ hdl/cbs_ctrl.sv @@
module cbs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output cbs_pkg::cmd_t cmd
);
  import cbs_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PREP = 9'b000000010,
    S_WMUL = 9'b000000100,
    S_WDIV = 9'b000001000,
    S_WWB  = 9'b000010000,
    S_PRD  = 9'b000100000,
    S_PMUL = 9'b001000000,
    S_PACC = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [OPI_W-1:0] op_cnt_r, op_cnt_nxt;
  logic [1:0]       pt_cnt_r, pt_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             take, out_load;

  assign in_ready = (state_r == S_IDLE);
  assign take     = in_valid && in_ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    op_cnt_nxt = op_cnt_r;
    pt_cnt_nxt = pt_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (take && in_op == OP_EVAL) state_nxt = S_PREP;
      end
      S_PREP: begin
        op_cnt_nxt = '0;
        state_nxt  = S_WMUL;
      end
      S_WMUL: state_nxt = S_WDIV;
      S_WDIV: state_nxt = S_WWB;
      S_WWB: begin
        if (op_cnt_r == OPI_W'(OPS_N - 1)) begin
          pt_cnt_nxt = '0;
          state_nxt  = S_PRD;
        end else begin
          op_cnt_nxt = op_cnt_r + 1'b1;
          state_nxt  = S_WMUL;
        end
      end
      S_PRD:  state_nxt = S_PMUL;
      S_PMUL: state_nxt = S_PACC;
      S_PACC: begin
        if (pt_cnt_r == 2'd3) begin
          state_nxt = S_OUT;
        end else begin
          pt_cnt_nxt = pt_cnt_r + 1'b1;
          state_nxt  = S_PRD;
        end
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result word held until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_cnt_r    <= '0;
      pt_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_cnt_r    <= op_cnt_nxt;
      pt_cnt_r    <= pt_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.take     = take;
    cmd.prep     = (state_r == S_PREP);
    cmd.wmul     = (state_r == S_WMUL);
    cmd.wdiv     = (state_r == S_WDIV);
    cmd.wwb      = (state_r == S_WWB);
    cmd.prd      = (state_r == S_PRD);
    cmd.pmul     = (state_r == S_PMUL);
    cmd.pacc     = (state_r == S_PACC);
    cmd.out_load = out_load;
    cmd.op_idx   = op_cnt_r;
    cmd.pt_idx   = pt_cnt_r;
  end

endmodule

@@ hdl/cbs_datapath.sv @@
module cbs_datapath #(
  parameter int MAX_POINTS = cbs_pkg::DEF_MAX_POINTS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cbs_pkg::cmd_t                    cmd,
  input  logic                             in_op,
  input  logic [cbs_pkg::PIDX_W-1:0]       point_index,
  input  logic signed [cbs_pkg::COMP_W-1:0] in_x,
  input  logic signed [cbs_pkg::COMP_W-1:0] in_y,
  input  logic signed [cbs_pkg::COMP_W-1:0] in_z,
  input  logic signed [cbs_pkg::COMP_W-1:0] in_w,
  input  logic [cbs_pkg::POS_W-1:0]        curve_pos,
  input  logic                             cfg_we,
  input  logic [cbs_pkg::CNT_W-1:0]        cfg_data,
  output logic signed [cbs_pkg::COMP_W-1:0] out_x,
  output logic signed [cbs_pkg::COMP_W-1:0] out_y,
  output logic signed [cbs_pkg::COMP_W-1:0] out_z,
  output logic signed [cbs_pkg::COMP_W-1:0] out_w,
  output logic [cbs_pkg::PIDX_W-1:0]       first_index
);
  import cbs_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic [1:0] DSEL_1 = 2'd1;
  localparam logic [1:0] DSEL_2 = 2'd2;
  localparam logic [1:0] DSEL_3 = 2'd3;
  localparam logic signed [PROD_W-1:0] RND_D1 = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] RND_D2 = PROD_W'(1) << FRAC_BITS;
  localparam logic signed [PROD_W-1:0] RND_D3 = PROD_W'(3) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0]  ACC_RND = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0]  SAT_HI = ACC_W'(32'h7FFF_FFFF);
  localparam logic signed [ACC_W-1:0]  SAT_LO = -ACC_W'(33'h0_8000_0000);
  localparam logic [POS_W-1:0]         POS_ONE = POS_W'(1) << FRAC_BITS;

  logic [4*COMP_W-1:0]      mem [MAX_POINTS];
  logic [4*COMP_W-1:0]      rdata_r;
  logic [CNT_W-1:0]         pc_r, n_clamp, n_r, q, first_c, first_r;
  logic [POS_W-1:0]         t_r;
  logic [U_W-1:0]           u_mul, u_c, u_r;
  logic signed [8:0]        kv [6];
  logic [CNT_W-1:0]         kk_c [6];
  logic [CNT_W-1:0]         kk_r [6];
  logic signed [WGT_W-1:0]  c_r [4];
  rop_t                     rop;
  logic signed [NUM_W-1:0]  kq, uq, num;
  logic signed [7:0]        dd;
  logic [1:0]               dsel_c, dsel_r;
  logic signed [PROD_W-1:0] prod_r, s1, s2, s3;
  logic signed [WGT_W-1:0]  x1_r, x2_r, q3, wres;
  logic [31:0]              y3;
  logic [63:0]              prod3_r;
  logic [30:0]              d3;
  logic signed [PP_W-1:0]   pp_r [4];
  logic signed [ACC_W-1:0]  acc_r [4];
  logic signed [ACC_W-1:0]  rs [4];
  logic signed [COMP_W-1:0] sat [4];
  logic [CNT_W-1:0]         rd_idx;

  // point count register
  always_ff @(posedge clk) begin
    if (!rst_n) pc_r <= CNT_W'(4);
    else if (cfg_we) pc_r <= cfg_data;
  end

  always_comb begin
    if (pc_r < CNT_W'(4)) n_clamp = CNT_W'(4);
    else if (int'(pc_r) > MAX_POINTS) n_clamp = CNT_W'(MAX_POINTS);
    else n_clamp = pc_r;
  end

  // control point table write
  always_ff @(posedge clk) begin
    if (cmd.take && in_op == OP_WRITE && int'(point_index) < MAX_POINTS) begin
      mem[AW'(point_index)] <= {in_w, in_z, in_y, in_x};
    end
  end

  // latch evaluate item
  always_ff @(posedge clk) begin
    if (cmd.take && in_op == OP_EVAL) begin
      t_r <= curve_pos;
      n_r <= n_clamp;
    end
  end

  // position, first index and clamped knots
  assign q     = n_r - CNT_W'(3);
  assign u_mul = {{(U_W-CNT_W){1'b0}}, q} * {{(U_W-POS_W){1'b0}}, t_r};

  always_comb begin
    if (t_r == '0) begin
      u_c     = '0;
      first_c = '0;
    end else if (t_r >= POS_ONE) begin
      u_c     = U_W'({q, {FRAC_BITS{1'b0}}});
      first_c = n_r - CNT_W'(4);
    end else begin
      u_c     = u_mul;
      first_c = u_mul[FRAC_BITS +: CNT_W];
    end
    for (int i = 0; i < 6; i++) begin
      kv[i] = signed'(9'({2'b00, first_c}) + 9'(i) - 9'd2);
      if (kv[i] <= 9'sd0) kk_c[i] = '0;
      else if (kv[i] >= signed'({2'b00, q})) kk_c[i] = q;
      else kk_c[i] = kv[i][CNT_W-1:0];
    end
  end

  // weight step operands
  assign rop = recur_op(cmd.op_idx);
  assign kq  = signed'(NUM_W'({kk_r[rop.ka], {FRAC_BITS{1'b0}}}));
  assign uq  = signed'(NUM_W'(u_r));
  assign num = rop.u_minus ? (uq - kq) : (kq - uq);
  assign dd  = signed'({1'b0, kk_r[rop.dk0]}) - signed'({1'b0, kk_r[rop.dk1]});

  always_comb begin
    if (dd == 8'sd2) dsel_c = DSEL_2;
    else if (dd == 8'sd3) dsel_c = DSEL_3;
    else dsel_c = DSEL_1;
  end

  // rounded divide by span times one
  assign s1 = (prod_r + RND_D1) >>> FRAC_BITS;
  assign s2 = (prod_r + RND_D2) >>> (FRAC_BITS + 1);
  assign s3 = (prod_r + RND_D3) >>> FRAC_BITS;
  assign y3 = s3[31:0] + DIV3_BIAS;
  assign d3 = prod3_r[63:33] - DIV3_OFF;
  assign q3 = signed'(d3[WGT_W-1:0]);

  always_comb begin
    case (dsel_r)
      DSEL_2:  wres = x2_r;
      DSEL_3:  wres = q3;
      default: wres = x1_r;
    endcase
  end

  // prep, weight multiply, divide and write back
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      u_r     <= u_c;
      first_r <= first_c;
      kk_r    <= kk_c;
      c_r[0]  <= '0;
      c_r[1]  <= '0;
      c_r[2]  <= '0;
      c_r[3]  <= WGT_W'(1) << FRAC_BITS;
    end
    if (cmd.wmul) begin
      prod_r <= num * c_r[rop.src];
      dsel_r <= dsel_c;
    end
    if (cmd.wdiv) begin
      x1_r    <= WGT_W'(s1);
      x2_r    <= WGT_W'(s2);
      prod3_r <= {32'b0, y3} * {32'b0, RECIP3};
    end
    if (cmd.wwb) begin
      if (rop.acc) c_r[rop.tgt] <= c_r[rop.tgt] + wres;
      else c_r[rop.tgt] <= wres;
    end
  end

  // control point read
  assign rd_idx = first_r + CNT_W'(cmd.pt_idx);

  always_ff @(posedge clk) begin
    if (cmd.prd) rdata_r <= mem[AW'(rd_idx)];
  end

  // weighted sum, one point per pass
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (cmd.pmul) pp_r[i] <= c_r[cmd.pt_idx] * signed'(rdata_r[i*COMP_W +: COMP_W]);
      if (cmd.prep) acc_r[i] <= '0;
      else if (cmd.pacc) acc_r[i] <= acc_r[i] + ACC_W'(pp_r[i]);
    end
  end

  // round and saturate
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rs[i] = (acc_r[i] + ACC_RND) >>> FRAC_BITS;
      if (rs[i] > SAT_HI) sat[i] = 32'sh7FFF_FFFF;
      else if (rs[i] < SAT_LO) sat[i] = 32'sh8000_0000;
      else sat[i] = rs[i][COMP_W-1:0];
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_x       <= sat[0];
      out_y       <= sat[1];
      out_z       <= sat[2];
      out_w       <= sat[3];
      first_index <= first_r[PIDX_W-1:0];
    end
  end

endmodule

@@ hdl/cbs_checker.sv @@
module cbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x
);
  import cbs_pkg::*;

  // stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // stalled result word keeps its x value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x))
    else $error("result word changed while stalled");

  // an accepted evaluate closes the input
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_EVAL |=> !in_ready)
    else $error("input open right after evaluate");

  // point writes never stall the input
  a_write_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_WRITE |=> in_ready)
    else $error("input closed after point write");

  // a new result appears only out of a busy evaluate
  a_out_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word without evaluate");

endmodule

bind cubic_bspline_evaluator cbs_checker u_cbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_port.valid),
  .in_ready  (in_port.ready),
  .in_op     (in_port.op),
  .out_valid (out_port.valid),
  .out_ready (out_port.ready),
  .out_x     (out_port.out_x)
);

@@ sim/cubic_bspline_evaluator_tb.sv @@
`timescale 1ns / 1ps

module cubic_bspline_evaluator_tb;
  import cbs_pkg::*;

  localparam int TBL_DEPTH = 64;
  localparam longint ONE   = 64'sd1 << FRAC_BITS;

  typedef struct {
    logic                     op;
    logic [PIDX_W-1:0]        idx;
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
    logic signed [COMP_W-1:0] w;
    logic [POS_W-1:0]         pos;
  } in_word_t;

  typedef struct {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
    logic signed [COMP_W-1:0] w;
    logic [PIDX_W-1:0]        first;
  } point_word_t;

  // floor division for a positive divisor
  function automatic longint div_floor(longint a, longint b);
    if (a >= 0) return a / b;
    return -((-a + b - 1) / b);
  endfunction

  // one basis recurrence term, rounded half up
  function automatic longint basis_term(longint num, longint wt, longint span);
    longint q;
    if (span <= 0) span = 1;
    q = span * ONE;
    return div_floor(num * wt + q / 2, q);
  endfunction

  function automatic logic signed [COMP_W-1:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[COMP_W-1:0];
  endfunction

  // curve predictor and store of expected evaluated points
  class spline_scoreboard;
    logic signed [COMP_W-1:0] pts [TBL_DEPTH][4];
    logic [CNT_W-1:0]         count;
    point_word_t              due_points[$];

    function new();
      count = 7'd4;
      foreach (pts[i, j]) pts[i][j] = '0;
    endfunction

    function void set_count(logic [CNT_W-1:0] v);
      count = v;
    endfunction

    function int pending();
      return due_points.size();
    endfunction

    function void note_input(in_word_t it);
      longint n, q, t, u, first, k, s, span;
      longint knots[6];
      longint c[4];
      int k0, k1;
      point_word_t p;
      if (it.op == OP_WRITE) begin
        pts[it.idx][0] = it.x;
        pts[it.idx][1] = it.y;
        pts[it.idx][2] = it.z;
        pts[it.idx][3] = it.w;
        return;
      end
      n = count;
      if (n < 4) n = 4;
      if (n > TBL_DEPTH) n = TBL_DEPTH;
      q = n - 3;
      t = it.pos;
      if (t <= 0) begin
        u = 0;
        first = 0;
      end else if (t >= ONE) begin
        u = q * ONE;
        first = n - 4;
      end else begin
        u = q * t;
        first = u >>> FRAC_BITS;
      end
      // clamped integer knots around the span
      for (int i = 0; i < 6; i++) begin
        k = first + 1 + i;
        if (k <= 3) knots[i] = 0;
        else if (k >= n) knots[i] = q * ONE;
        else knots[i] = (k - 3) * ONE;
      end
      // cox-de boor, degree three
      c[0] = 0; c[1] = 0; c[2] = 0; c[3] = ONE;
      for (int row = 2; row >= 0; row--) begin
        k0 = 3;
        k1 = row;
        span = (knots[k0] - knots[k1]) >>> FRAC_BITS;
        c[row] = basis_term(knots[k0] - u, c[row + 1], span);
        for (int col = row + 1; col < 3; col++) begin
          c[col] = basis_term(u - knots[k1], c[col], span);
          k0++;
          k1++;
          span = (knots[k0] - knots[k1]) >>> FRAC_BITS;
          c[col] += basis_term(knots[k0] - u, c[col + 1], span);
        end
        c[3] = basis_term(u - knots[k1], c[3], span);
      end
      // weighted sum of four points per component
      for (int comp = 0; comp < 4; comp++) begin
        s = 0;
        for (int j = 0; j < 4; j++)
          if (first + j < TBL_DEPTH) s += c[j] * longint'(pts[first + j][comp]);
        s = div_floor(s + ONE / 2, ONE);
        case (comp)
          0: p.x = clip32(s);
          1: p.y = clip32(s);
          2: p.z = clip32(s);
          default: p.w = clip32(s);
        endcase
      end
      p.first = first[PIDX_W-1:0];
      due_points.insert(due_points.size(), p);
    endfunction

    function bit check_result(point_word_t got, output string msg);
      point_word_t e;
      if (due_points.size() == 0) begin
        msg = $sformatf("unexpected result word x=%h first=%0d", got.x, got.first);
        return 0;
      end
      e = due_points.pop_front();
      if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.w !== e.w ||
          got.first !== e.first) begin
        msg = $sformatf("got %h %h %h %h f%0d, want %h %h %h %h f%0d",
                        got.x, got.y, got.z, got.w, got.first,
                        e.x, e.y, e.z, e.w, e.first);
        return 0;
      end
      msg = "";
      return 1;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   err_count = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  spline_scoreboard sb = new();

  cbs_in_if  in_if();
  cbs_out_if out_if();
  cbs_cfg_if cfg_if();

  cubic_bspline_evaluator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_if),
    .out_port (out_if),
    .cfg_port (cfg_if)
  );

  always #5 clk = ~clk;

  initial begin
    in_if.valid       = 1'b0;
    in_if.op          = OP_WRITE;
    in_if.point_index = '0;
    in_if.in_x        = '0;
    in_if.in_y        = '0;
    in_if.in_z        = '0;
    in_if.in_w        = '0;
    in_if.curve_pos   = '0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = '0;
  end

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // result side: check every accepted word, stall at random
  always @(posedge clk) begin
    point_word_t got;
    string msg;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.x = out_if.out_x;
      got.y = out_if.out_y;
      got.z = out_if.out_z;
      got.w = out_if.out_w;
      got.first = out_if.first_index;
      if (!sb.check_result(got, msg)) report(msg);
    end
    out_if.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_word(in_word_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.op          <= it.op;
    in_if.point_index <= it.idx;
    in_if.in_x        <= it.x;
    in_if.in_y        <= it.y;
    in_if.in_z        <= it.z;
    in_if.in_w        <= it.w;
    in_if.curve_pos   <= it.pos;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(it);
  endtask

  function automatic logic signed [COMP_W-1:0] rand_comp();
    case ($urandom_range(3))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      default: return COMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(9))
      0: return '0;
      1: return 17'd65536;
      2: return POS_W'($urandom_range(131071, 65537));
      default: return POS_W'($urandom_range(65535, 1));
    endcase
  endfunction

  function automatic in_word_t make_write(int slot);
    in_word_t it;
    it.op  = OP_WRITE;
    it.idx = PIDX_W'(slot);
    it.x   = rand_comp();
    it.y   = rand_comp();
    it.z   = rand_comp();
    it.w   = rand_comp();
    it.pos = POS_W'($urandom);
    return it;
  endfunction

  function automatic in_word_t make_eval(logic [POS_W-1:0] pos);
    in_word_t it;
    it     = make_write($urandom_range(63));
    it.op  = OP_EVAL;
    it.pos = pos;
    return it;
  endfunction

  // drain, let the block settle, then write the count register
  task automatic set_point_count(logic [CNT_W-1:0] v);
    in_if.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    sb.set_count(v);
  endtask

  initial begin
    logic [CNT_W-1:0] counts[7];
    int span_n;
    int done;
    in_word_t it;
    counts = '{7'd64, 7'd0, 7'd127, 7'd5, 7'd17, 7'd4, 7'd33};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes at the reset count of four
    tx_idle_pct = 13;
    rx_idle_pct = 65;
    it = make_write(0);
    it.x = 32'sh7FFF_FFFF; it.y = 32'sh8000_0000; it.z = '0; it.w = 32'sh0001_0000;
    send_word(it);
    it = make_write(1);
    it.x = 32'sh7FFF_FFFF; it.y = 32'sh8000_0000; it.z = 32'shFFFF_FFFF; it.w = '0;
    send_word(it);
    it = make_write(2);
    it.x = 32'sh7FFF_FFFF; it.y = 32'sh8000_0000; it.z = 32'sh0000_0001; it.w = '1;
    send_word(it);
    it = make_write(3);
    it.x = 32'sh7FFF_FFFF; it.y = 32'sh8000_0000; it.z = 32'sh5555_5555; it.w = '0;
    send_word(it);
    send_word(make_eval(17'd0));
    send_word(make_eval(17'd65536));
    send_word(make_eval(17'h1FFFF));
    send_word(make_eval(17'd32768));
    send_word(make_eval(17'd1));
    send_word(make_eval(17'd65535));
    send_word(make_write(63));
    send_word(make_eval(17'd21845));

    // random phases over several counts
    done = 0;
    foreach (counts[p]) begin
      set_point_count(counts[p]);
      span_n = counts[p] < 4 ? 4 : (counts[p] > TBL_DEPTH ? TBL_DEPTH : counts[p]);
      // fill every slot the curve can read
      for (int s = 0; s < span_n; s++) send_word(make_write(s));
      for (int i = 0; i < 200; i++) begin
        if (done < 470) begin
          tx_idle_pct = 13; rx_idle_pct = 65;
        end else if (done < 940) begin
          tx_idle_pct = 65; rx_idle_pct = 13;
        end else begin
          tx_idle_pct = 0; rx_idle_pct = 0;
        end
        if ($urandom_range(99) < 70) send_word(make_eval(rand_pos()));
        else send_word(make_write($urandom_range(63)));
        done++;
      end
    end

    in_if.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ cubic_bspline_evaluator.f @@
hdl/cbs_pkg.sv
hdl/cbs_ifs.sv
hdl/cbs_ctrl.sv
hdl/cbs_datapath.sv
hdl/cubic_bspline_evaluator.sv
hdl/cbs_checker.sv
sim/cubic_bspline_evaluator_tb.sv
